/* rtl/core/smft_pkg.sv */
// ----------------------------------------------------------------------------
// smft_pkg
// Shared types and constants of the sparse matrix fast transpose block.
// ----------------------------------------------------------------------------
`default_nettype none

package smft_pkg;

  localparam int unsigned MaxTermsDef  = 64;
  localparam int unsigned MaxDimDef    = 16;
  localparam int unsigned ValueBitsDef = 16;

  localparam int unsigned CoordW = 4;
  localparam int unsigned RegW   = 5;
  localparam int unsigned ApbDw  = 32;
  localparam int unsigned ApbAw  = 3;

  localparam logic [RegW-1:0] DimReset = 5'd16;

  localparam logic RegNumRows = 1'b0;
  localparam logic RegNumCols = 1'b1;

  typedef struct packed {
    logic accept;
    logic clr_idx;
    logic prefix_step;
    logic scatter_issue;
    logic out_load;
    logic empty_load;
    logic clear_load;
  } smft_cmd_t;

  typedef struct packed {
    logic idx_last_dim;
    logic issue_done;
    logic pipe_busy;
    logic n_zero;
    logic idx_last_term;
    logic out_free;
  } smft_sts_t;

endpackage

`default_nettype wire

/* rtl/core/sparse_matrix_fast_transpose.sv */
// ----------------------------------------------------------------------------
// sparse_matrix_fast_transpose
// Loads sparse matrix triplets, transposes them by counting and scattering,
// and streams the transposed triplets in row-major order.
// ----------------------------------------------------------------------------
// Channel  | Handshake             | Payload
// ---------+-----------------------+------------------------------------------
// input    | in_valid_i/in_ready_o | in_present, in_row, in_col, in_value, in_last
// result   | res_valid_o/res_ready_i | out_valid, out_row, out_col, out_value,
//          |                       | out_last, dropped
// config   | APB psel/penable      | num_rows (0x0), col_dim (0x4)
//
// Input transactions are taken one per cycle while loading. The closing
// transaction starts a prefix pass over the column counters and, unless no
// term was kept, a scatter pass through the term RAM's registered read port.
// Results are then read one at a time from the transposed RAM's registered
// port into the output register. Reset needs no clearing pass. A stalled
// result holds the output register and the block waits until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_matrix_fast_transpose import smft_pkg::*; #(
  parameter int unsigned MAX_TERMS  = MaxTermsDef,
  parameter int unsigned MAX_DIM    = MaxDimDef,
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ApbAw-1:0]             paddr,
  input  wire logic [ApbDw-1:0]             pwdata,
  output      logic [ApbDw-1:0]             prdata,
  output      logic                         pready,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic                         in_present_i,
  input  wire logic [CoordW-1:0]            in_row_i,
  input  wire logic [CoordW-1:0]            in_col_i,
  input  wire logic signed [VALUE_BITS-1:0] in_value_i,
  input  wire logic                         in_last_i,
  output      logic                         res_valid_o,
  input  wire logic                         res_ready_i,
  output      logic                         out_valid_o,
  output      logic [CoordW-1:0]            out_row_o,
  output      logic [CoordW-1:0]            out_col_o,
  output      logic signed [VALUE_BITS-1:0] out_value_o,
  output      logic                         out_last_o,
  output      logic                         dropped_o
);

  logic [RegW-1:0] num_rows_q, col_dim_q;
  logic            reg_sel;
  logic            cfg_wr;
  smft_cmd_t       cmd;
  smft_sts_t       sts;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = (reg_sel == RegNumCols) ? ApbDw'(col_dim_q) : ApbDw'(num_rows_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= DimReset;
      col_dim_q  <= DimReset;
    end else if (cfg_wr) begin
      case (reg_sel)
        RegNumRows: num_rows_q <= pwdata[RegW-1:0];
        RegNumCols: col_dim_q  <= pwdata[RegW-1:0];
        default:    num_rows_q <= num_rows_q;
      endcase
    end
  end

  smft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_last_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  smft_dp #(
    .MAX_TERMS  (MAX_TERMS),
    .MAX_DIM    (MAX_DIM),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .num_rows_i   (num_rows_q),
    .col_dim_i    (col_dim_q),
    .in_present_i (in_present_i),
    .in_row_i     (in_row_i),
    .in_col_i     (in_col_i),
    .in_value_i   (in_value_i),
    .res_valid_o  (res_valid_o),
    .res_ready_i  (res_ready_i),
    .out_valid_o  (out_valid_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .out_value_o  (out_value_o),
    .out_last_o   (out_last_o),
    .dropped_o    (dropped_o)
  );

endmodule

`default_nettype wire

/* rtl/core/smft_ram.sv */
// ----------------------------------------------------------------------------
// smft_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module smft_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/core/smft_ctrl.sv */
// ----------------------------------------------------------------------------
// smft_ctrl
// Controller that sequences load, prefix, scatter and output phases.
// ----------------------------------------------------------------------------
`default_nettype none

module smft_ctrl import smft_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_last_i,
  output      logic      in_ready_o,
  input  wire smft_sts_t sts_i,
  output      smft_cmd_t cmd_o
);

  localparam logic [2:0] StLoad    = 3'd0;
  localparam logic [2:0] StPrefix  = 3'd1;
  localparam logic [2:0] StScatter = 3'd2;
  localparam logic [2:0] StRead    = 3'd3;
  localparam logic [2:0] StOut     = 3'd4;
  localparam logic [2:0] StEmpty   = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StLoad: begin
        in_ready_o    = 1'b1;
        cmd_o.clr_idx = 1'b1;
        cmd_o.accept  = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = StPrefix;
        end
      end
      StPrefix: begin
        cmd_o.prefix_step = 1'b1;
        if (sts_i.idx_last_dim) begin
          cmd_o.clr_idx = 1'b1;
          state_d       = sts_i.n_zero ? StEmpty : StScatter;
        end
      end
      StScatter: begin
        if (!sts_i.issue_done) begin
          cmd_o.scatter_issue = 1'b1;
        end else if (!sts_i.pipe_busy) begin
          cmd_o.clr_idx = 1'b1;
          state_d       = StRead;
        end
      end
      StRead: begin
        state_d = StOut;
      end
      StOut: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.idx_last_term) begin
            cmd_o.clear_load = 1'b1;
            state_d          = StLoad;
          end else begin
            state_d = StRead;
          end
        end
      end
      StEmpty: begin
        if (sts_i.out_free) begin
          cmd_o.empty_load = 1'b1;
          cmd_o.clear_load = 1'b1;
          state_d          = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/smft_dp.sv */
// ----------------------------------------------------------------------------
// smft_dp
// Datapath: term stores, column counters, prefix sum and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module smft_dp import smft_pkg::*; #(
  parameter int unsigned MAX_TERMS  = MaxTermsDef,
  parameter int unsigned MAX_DIM    = MaxDimDef,
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire smft_cmd_t                    cmd_i,
  output      smft_sts_t                    sts_o,
  input  wire logic [RegW-1:0]              num_rows_i,
  input  wire logic [RegW-1:0]              col_dim_i,
  input  wire logic                         in_present_i,
  input  wire logic [CoordW-1:0]            in_row_i,
  input  wire logic [CoordW-1:0]            in_col_i,
  input  wire logic signed [VALUE_BITS-1:0] in_value_i,
  output      logic                         res_valid_o,
  input  wire logic                         res_ready_i,
  output      logic                         out_valid_o,
  output      logic [CoordW-1:0]            out_row_o,
  output      logic [CoordW-1:0]            out_col_o,
  output      logic signed [VALUE_BITS-1:0] out_value_o,
  output      logic                         out_last_o,
  output      logic                         dropped_o
);

  localparam int unsigned CntW   = $clog2(MAX_TERMS + 1);
  localparam int unsigned AddrW  = $clog2(MAX_TERMS);
  localparam int unsigned DimW   = $clog2(MAX_DIM);
  localparam int unsigned IdxMax = (MAX_TERMS > MAX_DIM) ? MAX_TERMS : MAX_DIM;
  localparam int unsigned IdxW   = $clog2(IdxMax + 1);
  localparam int unsigned LimW   = ($clog2(MAX_DIM + 1) > RegW) ? $clog2(MAX_DIM + 1) : RegW;
  localparam int unsigned EntW   = 2 * CoordW + VALUE_BITS;

  logic [CntW-1:0] counts_q [MAX_DIM];
  logic [CntW-1:0] term_cnt_q;
  logic [CntW-1:0] run_q;
  logic [IdxW-1:0] idx_q;
  logic            drop_q;
  logic            scat_v_q;

  logic [LimW-1:0]  lim_rows, lim_cols;
  logic             term_ok;
  logic [DimW-1:0]  ld_col, sc_col, pf_col;
  logic [EntW-1:0]  term_rd, trans_rd;
  logic [EntW-1:0]  term_wd, trans_wd;
  logic [AddrW-1:0] rd_addr, trans_wa;

  assign lim_rows = (LimW'(num_rows_i) > LimW'(MAX_DIM)) ? LimW'(MAX_DIM) : LimW'(num_rows_i);
  assign lim_cols = (LimW'(col_dim_i) > LimW'(MAX_DIM)) ? LimW'(MAX_DIM) : LimW'(col_dim_i);

  assign term_ok = in_present_i && (LimW'(in_row_i) < lim_rows) &&
                   (LimW'(in_col_i) < lim_cols) && (term_cnt_q < CntW'(MAX_TERMS));

  assign ld_col   = DimW'(in_col_i);
  assign sc_col   = DimW'(term_rd[EntW-CoordW-1 -: CoordW]);
  assign pf_col   = idx_q[DimW-1:0];
  assign rd_addr  = idx_q[AddrW-1:0];
  assign trans_wa = counts_q[sc_col][AddrW-1:0];
  assign term_wd  = {in_row_i, in_col_i, in_value_i};
  assign trans_wd = {term_rd[EntW-CoordW-1 -: CoordW], term_rd[EntW-1 -: CoordW],
                     term_rd[VALUE_BITS-1:0]};

  smft_ram #(
    .WIDTH (EntW),
    .DEPTH (MAX_TERMS)
  ) u_term_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && term_ok),
    .waddr_i (term_cnt_q[AddrW-1:0]),
    .wdata_i (term_wd),
    .raddr_i (rd_addr),
    .rdata_o (term_rd)
  );

  smft_ram #(
    .WIDTH (EntW),
    .DEPTH (MAX_TERMS)
  ) u_trans_ram (
    .clk_i   (clk_i),
    .we_i    (scat_v_q),
    .waddr_i (trans_wa),
    .wdata_i (trans_wd),
    .raddr_i (rd_addr),
    .rdata_o (trans_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_DIM; i++) begin
        counts_q[i] <= '0;
      end
      term_cnt_q <= '0;
      drop_q     <= 1'b0;
      run_q      <= '0;
      idx_q      <= '0;
      scat_v_q   <= 1'b0;
    end else begin
      scat_v_q <= cmd_i.scatter_issue;

      if (cmd_i.clear_load) begin
        for (int i = 0; i < MAX_DIM; i++) begin
          counts_q[i] <= '0;
        end
      end else if (cmd_i.accept && term_ok) begin
        counts_q[ld_col] <= counts_q[ld_col] + 1'b1;
      end else if (cmd_i.prefix_step) begin
        counts_q[pf_col] <= run_q;
      end else if (scat_v_q) begin
        counts_q[sc_col] <= counts_q[sc_col] + 1'b1;
      end

      if (cmd_i.clear_load) begin
        term_cnt_q <= '0;
        drop_q     <= 1'b0;
      end else if (cmd_i.accept && in_present_i) begin
        if (term_ok) begin
          term_cnt_q <= term_cnt_q + 1'b1;
        end else begin
          drop_q <= 1'b1;
        end
      end

      if (cmd_i.clr_idx) begin
        run_q <= '0;
      end else if (cmd_i.prefix_step) begin
        run_q <= run_q + counts_q[pf_col];
      end

      if (cmd_i.clr_idx) begin
        idx_q <= '0;
      end else if (cmd_i.prefix_step || cmd_i.scatter_issue || cmd_i.out_load) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else if (cmd_i.out_load || cmd_i.empty_load) begin
      res_valid_o <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
      out_row_o   <= trans_rd[EntW-1 -: CoordW];
      out_col_o   <= trans_rd[EntW-CoordW-1 -: CoordW];
      out_value_o <= trans_rd[VALUE_BITS-1:0];
      out_last_o  <= sts_o.idx_last_term;
      dropped_o   <= sts_o.idx_last_term && drop_q;
    end else if (cmd_i.empty_load) begin
      out_valid_o <= 1'b0;
      out_row_o   <= '0;
      out_col_o   <= '0;
      out_value_o <= '0;
      out_last_o  <= 1'b1;
      dropped_o   <= drop_q;
    end
  end

  always_comb begin
    sts_o.idx_last_dim  = (idx_q == IdxW'(MAX_DIM - 1));
    sts_o.issue_done    = (idx_q == IdxW'(term_cnt_q));
    sts_o.pipe_busy     = scat_v_q;
    sts_o.n_zero        = (term_cnt_q == '0);
    sts_o.idx_last_term = ((idx_q + 1'b1) == IdxW'(term_cnt_q));
    sts_o.out_free      = !res_valid_o || res_ready_i;
  end

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the sparse matrix fast transpose block.
// ----------------------------------------------------------------------------
// Source triplets are streamed in matrix by matrix. A scoreboard keeps its own
// copy of the dimension registers and of the loaded terms. When a matrix is
// closed, it predicts the transposed triplets by counting terms per column,
// taking a prefix sum and scattering. Every result transaction is checked
// field by field against the oldest prediction. A short directed part covers
// field extremes, out-of-range terms, empty matrices, saturating and zero
// dimensions. A random part of mostly well-formed row-major matrices follows,
// with noise items, store overflow and register changes between matrices.
// ----------------------------------------------------------------------------

module tb;
  import smft_pkg::*;

  localparam int RandomItems  = 280;
  localparam int SettleCycles = MaxDimDef + MaxTermsDef + 8;

  localparam logic [ApbAw-1:0] AddrNumRows = {RegNumRows, 2'b00};
  localparam logic [ApbAw-1:0] AddrNumCols = {RegNumCols, 2'b00};

  typedef struct packed {
    logic                    present;
    logic [CoordW-1:0]       row;
    logic [CoordW-1:0]       col;
    logic [ValueBitsDef-1:0] value;
    logic                    last;
  } src_item_t;

  typedef struct packed {
    logic                    valid;
    logic [CoordW-1:0]       row;
    logic [CoordW-1:0]       col;
    logic [ValueBitsDef-1:0] value;
    logic                    last;
    logic                    dropped;
  } xpose_res_t;

  class transpose_scoreboard;
    typedef struct packed {
      logic [CoordW-1:0]       row;
      logic [CoordW-1:0]       col;
      logic [ValueBitsDef-1:0] value;
    } term_t;

    logic [RegW-1:0] rows_reg = DimReset;
    logic [RegW-1:0] cols_reg = DimReset;
    term_t           held[MaxTermsDef];
    int              n_held = 0;
    int              per_col[MaxDimDef];
    bit              dropped_any = 1'b0;
    xpose_res_t      transposed_q[$];
    int              mismatches = 0;
    int              checked = 0;
    int              matrices = 0;
    int              lossy_matrices = 0;
    int              settings = 0;

    function new();
      foreach (per_col[c]) per_col[c] = 0;
    endfunction

    task report(string msg);
      $display("%0t ERROR: %s", $time, msg);
      mismatches++;
    endtask

    function int limit(logic [RegW-1:0] dim);
      return (dim > MaxDimDef) ? MaxDimDef : dim;
    endfunction

    function void take_term(src_item_t it);
      int         starts[MaxDimDef];
      int         pos;
      int         slot;
      term_t      placed[MaxTermsDef];
      xpose_res_t r;
      if (it.present) begin
        if (it.row >= limit(rows_reg) || it.col >= limit(cols_reg) ||
            n_held >= MaxTermsDef) begin
          dropped_any = 1'b1;
        end else begin
          held[n_held] = '{it.row, it.col, it.value};
          per_col[it.col]++;
          n_held++;
        end
      end
      if (!it.last) return;
      matrices++;
      if (dropped_any) lossy_matrices++;
      if (n_held == 0) begin
        r = '0;
        r.last = 1'b1;
        r.dropped = dropped_any;
        transposed_q.push_back(r);
      end else begin
        pos = 0;
        for (int c = 0; c < MaxDimDef; c++) begin
          starts[c] = pos;
          pos += per_col[c];
        end
        for (int i = 0; i < n_held; i++) begin
          slot = starts[held[i].col];
          starts[held[i].col]++;
          placed[slot] = '{held[i].col, held[i].row, held[i].value};
        end
        for (int i = 0; i < n_held; i++) begin
          r.valid = 1'b1;
          r.row = placed[i].row;
          r.col = placed[i].col;
          r.value = placed[i].value;
          r.last = (i == n_held - 1);
          r.dropped = r.last && dropped_any;
          transposed_q.push_back(r);
        end
      end
      n_held = 0;
      dropped_any = 1'b0;
      foreach (per_col[c]) per_col[c] = 0;
    endfunction

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("triplet %0d: %s is 0x%0h, expected 0x%0h", checked, name, got,
                         want));
    endtask

    task check_triplet(xpose_res_t got);
      xpose_res_t want;
      if (transposed_q.size() == 0) begin
        report($sformatf("unexpected triplet row %0d col %0d value 0x%0h",
                         got.row, got.col, got.value));
        return;
      end
      want = transposed_q.pop_front();
      checked++;
      compare_field("out_valid", got.valid, want.valid);
      compare_field("out_row", got.row, want.row);
      compare_field("out_col", got.col, want.col);
      compare_field("out_value", got.value, want.value);
      compare_field("out_last", got.last, want.last);
      compare_field("dropped", got.dropped, want.dropped);
    endtask
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ApbAw-1:0]        paddr;
  logic [ApbDw-1:0]        pwdata;
  logic [ApbDw-1:0]        prdata;
  logic                    pready;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    in_present_i;
  logic [CoordW-1:0]       in_row_i;
  logic [CoordW-1:0]       in_col_i;
  logic [ValueBitsDef-1:0] in_value_i;
  logic                    in_last_i;
  logic                    res_valid_o;
  logic                    res_ready_i;
  logic                    out_valid_o;
  logic [CoordW-1:0]       out_row_o;
  logic [CoordW-1:0]       out_col_o;
  logic [ValueBitsDef-1:0] out_value_o;
  logic                    out_last_o;
  logic                    dropped_o;

  transpose_scoreboard sb = new();
  bit                  in_steady;
  int                  terms_sent;

  always #4 clk_i = ~clk_i;

  sparse_matrix_fast_transpose DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_present_i (in_present_i),
    .in_row_i     (in_row_i),
    .in_col_i     (in_col_i),
    .in_value_i   (in_value_i),
    .in_last_i    (in_last_i),
    .res_valid_o  (res_valid_o),
    .res_ready_i  (res_ready_i),
    .out_valid_o  (out_valid_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .out_value_o  (out_value_o),
    .out_last_o   (out_last_o),
    .dropped_o    (dropped_o)
  );

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(24, 80);
  endfunction

  function automatic src_item_t mk_item(bit p, int r, int c, int v, bit l);
    src_item_t it;
    it.present = p;
    it.row = CoordW'(r);
    it.col = CoordW'(c);
    it.value = ValueBitsDef'(v);
    it.last = l;
    return it;
  endfunction

  function automatic logic [ValueBitsDef-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return ValueBitsDef'($urandom);
    endcase
  endfunction

  function automatic logic [RegW-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd16;
      3: return 5'd17;
      4: return 5'd31;
      default: return RegW'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [ApbDw-1:0] with_noise(logic [RegW-1:0] dim);
    logic [ApbDw-1:0] word;
    word = $urandom;
    word[RegW-1:0] = dim;
    return word;
  endfunction

  task automatic apb_access(input bit is_write, input logic [ApbAw-1:0] addr,
                            input logic [ApbDw-1:0] wdata, output logic [ApbDw-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
  endtask

  task automatic apb_release();
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_dims();
    logic [ApbDw-1:0] word;
    apb_access(1'b0, AddrNumRows, '0, word);
    if (word !== ApbDw'(sb.rows_reg))
      sb.report($sformatf("num_rows reads 0x%0h, expected 0x%0h", word, sb.rows_reg));
    apb_access(1'b0, AddrNumCols, '0, word);
    if (word !== ApbDw'(sb.cols_reg))
      sb.report($sformatf("col_dim reads 0x%0h, expected 0x%0h", word, sb.cols_reg));
  endtask

  task automatic set_dims(input logic [RegW-1:0] rows, input logic [RegW-1:0] cols);
    logic [ApbDw-1:0] unused;
    apb_access(1'b1, AddrNumRows, with_noise(rows), unused);
    sb.rows_reg = rows;
    apb_access(1'b1, AddrNumCols, with_noise(cols), unused);
    sb.cols_reg = cols;
    sb.settings++;
    check_dims();
    apb_release();
  endtask

  task automatic send_triplet(input src_item_t it);
    int gap;
    in_valid_i <= 1'b1;
    in_present_i <= it.present;
    in_row_i <= it.row;
    in_col_i <= it.col;
    in_value_i <= it.value;
    in_last_i <= it.last;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.take_term(it);
    gap = in_steady ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.transposed_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic send_random_matrix(input int n_terms);
    int        er;
    int        ec;
    int        cells;
    int        skip;
    int        pos;
    bit        close_empty;
    src_item_t it;
    er = sb.limit(sb.rows_reg);
    ec = sb.limit(sb.cols_reg);
    cells = er * ec;
    in_steady = ($urandom_range(0, 3) == 0);
    close_empty = (n_terms == 0) || ($urandom_range(0, 4) == 0);
    skip = (n_terms > 0 && cells > n_terms) ? (cells - n_terms) / n_terms : 0;
    pos = -1;
    for (int k = 0; k < n_terms; k++) begin
      pos += 1 + $urandom_range(0, skip);
      it.present = 1'b1;
      it.value = rand_value();
      it.last = !close_empty && (k == n_terms - 1);
      if (pos < cells && n_terms <= cells) begin
        it.row = CoordW'(pos / ec);
        it.col = CoordW'(pos % ec);
      end else begin
        it.row = CoordW'($urandom_range(0, (er > 0) ? er - 1 : 15));
        it.col = CoordW'($urandom_range(0, (ec > 0) ? ec - 1 : 15));
      end
      if ($urandom_range(0, 19) == 0) begin
        it.row = CoordW'($urandom);
        it.col = CoordW'($urandom);
      end
      if ($urandom_range(0, 24) == 0)
        send_triplet(mk_item(1'b0, $urandom, $urandom, $urandom, 1'b0));
      send_triplet(it);
      terms_sent++;
    end
    if (close_empty) begin
      send_triplet(mk_item(1'b0, $urandom, $urandom, $urandom, 1'b1));
      terms_sent++;
    end
  endtask

  always @(posedge clk_i) begin
    xpose_res_t seen;
    if (rst_ni === 1'b1 && res_valid_o === 1'b1 && res_ready_i === 1'b1) begin
      seen = {out_valid_o, out_row_o, out_col_o, out_value_o, out_last_o, dropped_o};
      sb.check_triplet(seen);
    end
  end

  initial begin : result_sink
    int hold;
    int span;
    bit steady;
    hold = 0;
    span = 0;
    steady = 1'b0;
    res_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (span == 0) begin
        steady = ($urandom_range(0, 3) == 0);
        span = $urandom_range(16, 96);
      end
      span--;
      if (steady) begin
        res_ready_i <= 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else if (res_ready_i) begin
        hold = idle_gap();
        if (hold > 0) begin
          res_ready_i <= 1'b0;
          hold--;
        end
      end else begin
        res_ready_i <= 1'b1;
        hold = $urandom_range(0, 6);
      end
    end
  end

  initial begin : stimulus
    int r;
    int n_terms;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid_i <= 1'b0;
    in_present_i <= 1'b0;
    in_row_i <= '0;
    in_col_i <= '0;
    in_value_i <= '0;
    in_last_i <= 1'b0;
    in_steady = 1'b0;
    terms_sent = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_dims();
    apb_release();

    send_triplet(mk_item(1'b1, 0, 0, 'h8000, 1'b0));
    send_triplet(mk_item(1'b0, 5, 9, 'h1111, 1'b0));
    send_triplet(mk_item(1'b1, 0, 15, 'h7FFF, 1'b0));
    send_triplet(mk_item(1'b1, 3, 7, 'hFFFF, 1'b0));
    send_triplet(mk_item(1'b1, 9, 0, 'h0001, 1'b0));
    send_triplet(mk_item(1'b1, 15, 0, 'h1234, 1'b0));
    send_triplet(mk_item(1'b1, 15, 15, 'hA5A5, 1'b1));
    send_triplet(mk_item(1'b0, 0, 0, 0, 1'b1));
    send_triplet(mk_item(1'b1, 2, 2, 'h0042, 1'b0));
    send_triplet(mk_item(1'b0, 15, 15, 'hFFFF, 1'b1));

    wait_drained();
    set_dims(5'd3, 5'd5);
    send_triplet(mk_item(1'b1, 0, 4, 'h0101, 1'b0));
    send_triplet(mk_item(1'b1, 2, 5, 'h0202, 1'b0));
    send_triplet(mk_item(1'b1, 3, 0, 'h0303, 1'b0));
    send_triplet(mk_item(1'b1, 2, 1, 'h0404, 1'b1));
    send_triplet(mk_item(1'b1, 7, 7, 'h0505, 1'b1));

    wait_drained();
    set_dims(5'd31, 5'd17);
    send_triplet(mk_item(1'b1, 15, 15, 'hC001, 1'b0));
    send_triplet(mk_item(1'b1, 15, 0, 'hC002, 1'b1));

    wait_drained();
    set_dims(5'd0, 5'd16);
    send_triplet(mk_item(1'b1, 0, 0, 'h0BAD, 1'b1));

    wait_drained();
    set_dims(5'd16, 5'd0);
    send_triplet(mk_item(1'b1, 4, 4, 'h0C0C, 1'b0));
    send_triplet(mk_item(1'b1, 1, 1, 'h0D0D, 1'b1));

    wait_drained();
    set_dims(5'd1, 5'd1);
    send_triplet(mk_item(1'b1, 0, 0, 'h1E1E, 1'b0));
    send_triplet(mk_item(1'b1, 0, 1, 'h2F2F, 1'b1));

    wait_drained();
    set_dims(DimReset, DimReset);
    send_random_matrix(70);
    while (terms_sent < RandomItems) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_drained();
        set_dims(pick_dim(), pick_dim());
      end
      r = $urandom_range(0, 99);
      if (r < 80) n_terms = $urandom_range(0, 8);
      else if (r < 94) n_terms = $urandom_range(9, 30);
      else n_terms = $urandom_range(56, 72);
      send_random_matrix(n_terms);
    end
    wait_drained();

    $display("Covered %0d matrices (%0d with dropped terms) over %0d dimension settings.",
             sb.matrices, sb.lossy_matrices, sb.settings);
    $display("Checked %0d result transactions; %0d random input transactions sent.",
             sb.checked, terms_sent);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("Timeout with %0d result transactions outstanding.", sb.transposed_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
